// File: design/lab_pkg.sv
// Shared types and constants for the look-at basis core.
// Used by lab_norm, lab_cross and look_at_basis_core; depends on nothing.
package lab_pkg;

  localparam int CoordWidth = 16;   // input coordinates, signed Q7.8
  localparam int UnitWidth  = 16;   // unit axis components, signed Q1.14
  localparam int UnitFrac   = 14;
  localparam int UnitOne    = 16384;
  localparam int VecWidth   = 32;   // signed components fed to normalization
  localparam int MagWidth   = 30;   // magnitudes after range reduction
  localparam int SqWidth    = 62;   // sum of three squares
  localparam int RootWidth  = 64;   // working width of the square root
  localparam int RootIters  = 32;   // one result bit per stage
  localparam int LenWidth   = 32;   // square root result
  localparam int QuotWidth  = 15;   // quotient, at most UnitOne
  localparam int NumWidth   = 47;   // dividend of the unit division
  localparam int KWidth     = 6;

  localparam int InDataWidth  = 6 * CoordWidth;
  localparam int OutDataWidth = 9 * UnitWidth;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegUpX = 2'd0;
  localparam logic [1:0] RegUpY = 2'd1;
  localparam logic [1:0] RegUpZ = 2'd2;

  typedef logic [2:0][VecWidth-1:0]  vec_t;
  typedef logic [2:0][UnitWidth-1:0] unit_vec_t;

  // Payload that rides along with an item through the arithmetic units.
  typedef struct packed {
    unit_vec_t f;
    logic      deg;
  } side_t;

  // Per-item context inside the normalization pipeline.
  typedef struct packed {
    logic [2:0][MagWidth-1:0] a;
    logic [2:0]               neg;
    logic                     zero;
    logic [KWidth-1:0]        k;
    side_t                    side;
  } nrm_ctx_t;

endpackage

// File: design/lab_cross.sv
// Pipelined cross product of two Q1.14-style 16-bit vectors.
// Depends on lab_pkg; two register stages (products, differences).
module lab_cross (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              vld_i,
  input  lab_pkg::unit_vec_t a_i,
  input  lab_pkg::unit_vec_t b_i,
  input  lab_pkg::side_t    side_i,
  output logic              vld_o,
  output lab_pkg::vec_t     r_o,
  output lab_pkg::side_t    side_o
);

  logic                 vld1_q, vld2_q;
  logic signed [31:0]   p_d [6];
  logic signed [31:0]   p_q [6];
  lab_pkg::side_t       side1_q, side2_q;
  lab_pkg::vec_t        r_d, r_q;
  logic signed [32:0]   dif [3];

  always_comb begin
    p_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    p_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    p_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    p_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    p_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    p_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = 33'(p_q[2*i]) - 33'(p_q[2*i+1]);
      // magnitudes stay well below 2^31
      r_d[i] = dif[i][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q     <= p_d;
      side1_q <= side_i;
      r_q     <= r_d;
      side2_q <= side1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign r_o    = r_q;
  assign side_o = side2_q;

endmodule

// File: design/lab_norm.sv
// Pipelined fixed-point normalization of a signed 3-vector to Q1.14.
// Depends on lab_pkg; range reduction, squares, bit-per-stage square root
// and bit-per-stage division, 55 register stages.
module lab_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  lab_pkg::vec_t      v_i,
  input  lab_pkg::side_t     side_i,
  output logic               vld_o,
  output lab_pkg::unit_vec_t u_o,
  output lab_pkg::side_t     side_o
);

  localparam int DivIters = lab_pkg::QuotWidth;

  // Even shift that brings the sum of squares up to 61 or 62 bits.
  function automatic logic [lab_pkg::KWidth-1:0] calc_k(
    input logic [lab_pkg::SqWidth-1:0] q
  );
    logic [6:0] bl;
    logic [6:0] kk;
    bl = '0;
    for (int i = 0; i < lab_pkg::SqWidth; i++) begin
      if (q[i]) bl = 7'(i + 1);
    end
    kk = (7'(lab_pkg::SqWidth) - bl) & ~7'd1;
    return kk[lab_pkg::KWidth-1:0];
  endfunction

  // stage 1: magnitudes and signs
  logic                          vld1_q;
  logic [2:0][31:0]              mag1_q;
  logic [2:0]                    neg1_q;
  lab_pkg::side_t                side1_q;
  // stage 2: range reduction
  logic                          vld2_q;
  logic [2:0][lab_pkg::MagWidth-1:0] a2_q;
  logic [2:0]                    neg2_q;
  logic                          zero2_q;
  lab_pkg::side_t                side2_q;
  // stage 3: squares
  logic                          vld3_q;
  logic [2:0][2*lab_pkg::MagWidth-1:0] sq3_q;
  lab_pkg::nrm_ctx_t             c3_q;
  // stage 4: sum
  logic                          vld4_q;
  logic [lab_pkg::SqWidth-1:0]   q4_q;
  lab_pkg::nrm_ctx_t             c4_q;
  // stage 5: shift amount
  logic                          vld5_q;
  logic [lab_pkg::SqWidth-1:0]   q5_q;
  lab_pkg::nrm_ctx_t             c5_q;

  logic [31:0]                   mx;
  logic [1:0]                    sh;
  lab_pkg::nrm_ctx_t             c3_d, c5_d;

  // square root pipeline, index 0 is the shifted operand
  logic                          rv_q [lab_pkg::RootIters+1];
  logic [lab_pkg::RootWidth-1:0] rx_q [lab_pkg::RootIters+1];
  logic [lab_pkg::RootWidth-1:0] rr_q [lab_pkg::RootIters+1];
  lab_pkg::nrm_ctx_t             rc_q [lab_pkg::RootIters+1];

  // division pipeline, index 0 is the setup stage
  logic                                  dv_q [DivIters+1];
  logic [2:0][lab_pkg::NumWidth-1:0]     dn_q [DivIters+1];
  logic [2:0][lab_pkg::QuotWidth-1:0]    dq_q [DivIters+1];
  logic [lab_pkg::LenWidth-1:0]          dd_q [DivIters+1];
  lab_pkg::nrm_ctx_t                     dc_q [DivIters+1];

  logic [lab_pkg::LenWidth-1:0]          len;
  logic [lab_pkg::KWidth-1:0]            h;
  logic [2:0][lab_pkg::NumWidth-1:0]     n0_d;

  // final stage
  logic                          vldf_q;
  lab_pkg::unit_vec_t            uf_d, uf_q;
  lab_pkg::side_t                sidef_d, sidef_q;
  logic [lab_pkg::QuotWidth-1:0] qc;

  always_comb begin
    mx = (mag1_q[0] > mag1_q[1]) ? mag1_q[0] : mag1_q[1];
    mx = (mx > mag1_q[2]) ? mx : mag1_q[2];
    if (mx[31])      sh = 2'd2;
    else if (mx[30]) sh = 2'd1;
    else             sh = 2'd0;
  end

  always_comb begin
    c3_d      = '0;
    c3_d.a    = a2_q;
    c3_d.neg  = neg2_q;
    c3_d.zero = zero2_q;
    c3_d.side = side2_q;
    c5_d      = c4_q;
    c5_d.k    = calc_k(q4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      rv_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      rv_q[0] <= vld5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= v_i[i][31];
        mag1_q[i] <= v_i[i][31] ? (32'd0 - v_i[i]) : v_i[i];
        a2_q[i]   <= 30'(mag1_q[i] >> sh);
        sq3_q[i]  <= a2_q[i] * a2_q[i];
      end
      side1_q <= side_i;
      neg2_q  <= neg1_q;
      zero2_q <= (mx == 32'd0);
      side2_q <= side1_q;
      c3_q    <= c3_d;
      q4_q    <= 62'(sq3_q[0]) + 62'(sq3_q[1]) + 62'(sq3_q[2]);
      c4_q    <= c3_q;
      q5_q    <= q4_q;
      c5_q    <= c5_d;
      rx_q[0] <= 64'(q5_q) << c5_q.k;
      rr_q[0] <= '0;
      rc_q[0] <= c5_q;
    end
  end

  // One result bit per stage: compare, subtract, shift.
  for (genvar j = 0; j < lab_pkg::RootIters; j++) begin : g_root
    localparam logic [lab_pkg::RootWidth-1:0] Bit = 64'(1) << (62 - 2*j);
    logic [lab_pkg::RootWidth-1:0] t;
    logic [lab_pkg::RootWidth-1:0] x_d, r_d;

    always_comb begin
      t = rr_q[j] + Bit;
      if (rx_q[j] >= t) begin
        x_d = rx_q[j] - t;
        r_d = (rr_q[j] >> 1) + Bit;
      end else begin
        x_d = rx_q[j];
        r_d = rr_q[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[j+1] <= 1'b0;
      end else if (adv_i) begin
        rv_q[j+1] <= rv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rx_q[j+1] <= x_d;
        rr_q[j+1] <= r_d;
        rc_q[j+1] <= rc_q[j];
      end
    end
  end

  // Division setup: dividend is the magnitude scaled up, plus half the length.
  always_comb begin
    len = rr_q[lab_pkg::RootIters][lab_pkg::LenWidth-1:0];
    h   = 6'(lab_pkg::UnitFrac) + {1'b0, rc_q[lab_pkg::RootIters].k[lab_pkg::KWidth-1:1]};
    for (int i = 0; i < 3; i++) begin
      n0_d[i] = (47'(rc_q[lab_pkg::RootIters].a[i]) << h) + 47'(len >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dv_q[0] <= rv_q[lab_pkg::RootIters];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dn_q[0] <= n0_d;
      dq_q[0] <= '0;
      dd_q[0] <= len;
      dc_q[0] <= rc_q[lab_pkg::RootIters];
    end
  end

  // Restoring division, one quotient bit per stage, three lanes.
  for (genvar m = 0; m < DivIters; m++) begin : g_div
    localparam int S = DivIters - 1 - m;
    logic [lab_pkg::NumWidth-1:0] cmp;
    logic [2:0][lab_pkg::NumWidth-1:0]  n_d;
    logic [2:0][lab_pkg::QuotWidth-1:0] q_d;

    always_comb begin
      cmp = 47'(dd_q[m]) << S;
      for (int i = 0; i < 3; i++) begin
        n_d[i] = dn_q[m][i];
        q_d[i] = dq_q[m][i];
        if (dn_q[m][i] >= cmp) begin
          n_d[i]    = dn_q[m][i] - cmp;
          q_d[i][S] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[m+1] <= 1'b0;
      end else if (adv_i) begin
        dv_q[m+1] <= dv_q[m];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dn_q[m+1] <= n_d;
        dq_q[m+1] <= q_d;
        dd_q[m+1] <= dd_q[m];
        dc_q[m+1] <= dc_q[m];
      end
    end
  end

  // Saturate, restore sign, flag a zero vector.
  always_comb begin
    qc = '0;
    for (int i = 0; i < 3; i++) begin
      qc = dq_q[DivIters][i];
      if (qc > 15'(lab_pkg::UnitOne)) qc = 15'(lab_pkg::UnitOne);
      uf_d[i] = dc_q[DivIters].neg[i] ? (16'd0 - {1'b0, qc}) : {1'b0, qc};
    end
    sidef_d     = dc_q[DivIters].side;
    sidef_d.deg = dc_q[DivIters].side.deg | dc_q[DivIters].zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (adv_i) begin
      vldf_q <= dv_q[DivIters];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      uf_q    <= uf_d;
      sidef_q <= sidef_d;
    end
  end

  assign vld_o  = vldf_q;
  assign u_o    = uf_q;
  assign side_o = sidef_q;

endmodule

// File: design/look_at_basis_core.sv
// Top level of the look-at camera basis core: stream ports, up-vector
// registers on an APB-style port, and the normalize/cross pipeline.
// Depends on lab_pkg, lab_norm and lab_cross.
//
// Use: send one item (eye point, target point, Q7.8) on the s_axis channel;
// one item comes back on m_axis with the side, recomputed up and back axes
// as Q1.14 unit vectors, and tuser set when the basis is degenerate (eye on
// the target, or up parallel to the view direction), in which case all nine
// components are zero. The world up vector lives in three registers at
// byte addresses 0, 4 and 8; write them only while no item is in flight.
// The pipeline runs input difference, forward normalization, side cross
// product, side normalization, up cross product and output rounding
// register in that order. Each normalization is 55 stages, most of them
// in the square root, one result bit per stage (32), and the division,
// one quotient bit per stage (15). One item enters per cycle unless the output stalls.
// Reset empties the pipeline and loads up = (0, 1/64, 0) in Q1.14.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
module look_at_basis_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z (lowest bits first)
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // side_x/y/z, true_up_x/y/z, back_x/y/z (lowest bits first)
  output logic [143:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic                adv;
  lab_pkg::unit_vec_t  up_q;

  logic                vld0_q;
  lab_pkg::vec_t       d_d, d_q;

  logic                n1_vld, c1_vld, n2_vld, c2_vld;
  lab_pkg::unit_vec_t  f_u, s_u;
  lab_pkg::side_t      n1_side, c1_side_in, c1_side, n2_side, c2_side;
  lab_pkg::vec_t       sc, uv;

  logic                out_vld_q;
  logic [143:0]        out_data_d, out_data_q;
  logic                out_deg_q;
  logic [31:0]         um;
  logic [17:0]         ur;
  logic [15:0]         uq;

  // Advance the whole pipeline unless a finished item is held at the output.
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign pready        = 1'b1;

  // Up-vector registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= 16'd0;
      up_q[1] <= 16'd256;
      up_q[2] <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        lab_pkg::RegUpX: up_q[0] <= pwdata[15:0];
        lab_pkg::RegUpY: up_q[1] <= pwdata[15:0];
        lab_pkg::RegUpZ: up_q[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lab_pkg::RegUpX: prdata = {16'd0, up_q[0]};
      lab_pkg::RegUpY: prdata = {16'd0, up_q[1]};
      lab_pkg::RegUpZ: prdata = {16'd0, up_q[2]};
      default:         prdata = 32'd0;
    endcase
  end

  // View direction: target minus eye, sign-extended to full width.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {{16{s_axis_tdata[48+16*i+15]}}, s_axis_tdata[48+16*i +: 16]}
             - {{16{s_axis_tdata[16*i+15]}}, s_axis_tdata[16*i +: 16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (adv) begin
      vld0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q <= d_d;
    end
  end

  // Forward axis.
  lab_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (vld0_q),
    .v_i    (d_q),
    .side_i ('0),
    .vld_o  (n1_vld),
    .u_o    (f_u),
    .side_o (n1_side)
  );

  always_comb begin
    c1_side_in     = n1_side;
    c1_side_in.f   = f_u;
  end

  // Side direction: forward cross up.
  lab_cross u_cross_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (n1_vld),
    .a_i    (f_u),
    .b_i    (up_q),
    .side_i (c1_side_in),
    .vld_o  (c1_vld),
    .r_o    (sc),
    .side_o (c1_side)
  );

  lab_norm u_norm_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (c1_vld),
    .v_i    (sc),
    .side_i (c1_side),
    .vld_o  (n2_vld),
    .u_o    (s_u),
    .side_o (n2_side)
  );

  // Recomputed up: side cross forward, Q2.28; the payload carries f along.
  lab_cross u_cross_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (n2_vld),
    .a_i    (s_u),
    .b_i    (n2_side.f),
    .side_i (n2_side),
    .vld_o  (c2_vld),
    .r_o    (uv),
    .side_o (c2_side)
  );

  // Side must wait for the up cross product, so delay it two stages too.
  lab_pkg::unit_vec_t  s1_q, s2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s_u;
      s2_q <= s1_q;
    end
  end

  // Round up axis half away from zero to Q1.14, saturate; back = -forward.
  always_comb begin
    um = '0;
    ur = '0;
    uq = '0;
    out_data_d = '0;
    for (int i = 0; i < 3; i++) begin
      um = uv[i][31] ? (32'd0 - uv[i]) : uv[i];
      ur = 18'((um + 32'd8192) >> lab_pkg::UnitFrac);
      if (ur > 18'(lab_pkg::UnitOne)) ur = 18'(lab_pkg::UnitOne);
      uq = uv[i][31] ? (16'd0 - ur[15:0]) : ur[15:0];
      out_data_d[16*i +: 16]      = s2_q[i];
      out_data_d[48 + 16*i +: 16] = uq;
      out_data_d[96 + 16*i +: 16] = 16'd0 - c2_side.f[i];
    end
    if (c2_side.deg) out_data_d = '0;
  end

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_deg_q  <= c2_side.deg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_deg_q;

endmodule

// File: design/lab_chk.sv
// Port-level checks for the look-at basis core, bound to the top level.
// Depends on look_at_basis_core port names only.
module lab_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // A held result stalls the input side.
  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Degenerate basis carries only zeros.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate item with nonzero axes");

  // A regular basis has a nonzero back axis.
  a_back_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[143:96] != '0)
    else $error("zero back axis on regular item");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");

endmodule

bind look_at_basis_core lab_chk u_lab_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
